[hw/rtl/qfe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qfe_pkg
// shared constants, codes and controller/datapath command types
// ----------------------------------------------------------------------------
package qfe_pkg;

    localparam int NUM_VARIABLES = 8;
    localparam int IDX_W         = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;
    localparam int A_DEPTH       = NUM_VARIABLES * NUM_VARIABLES;
    localparam int A_AW          = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;

    // transaction modes
    localparam logic [2:0] MODE_WR_QUAD  = 3'd0;
    localparam logic [2:0] MODE_WR_LIN   = 3'd1;
    localparam logic [2:0] MODE_WR_CONST = 3'd2;
    localparam logic [2:0] MODE_EVAL     = 3'd3;
    localparam logic [2:0] MODE_TRANS    = 3'd4;
    localparam logic [2:0] MODE_CLEAR    = 3'd5;

    // sequencer term steps
    localparam logic [2:0] STEP_LIN  = 3'd0; // b[i]*x[i] into sum
    localparam logic [2:0] STEP_XX   = 3'd1; // x[i]*x[j], kept
    localparam logic [2:0] STEP_XXA  = 3'd2; // (x[i]*x[j])*a into sum
    localparam logic [2:0] STEP_BI   = 3'd3; // a*x[j] into b[i]
    localparam logic [2:0] STEP_BJ   = 3'd4; // a*x[i] into b[j]
    localparam logic [2:0] STEP_AXI  = 3'd5; // a*x[i], kept
    localparam logic [2:0] STEP_AXIJ = 3'd6; // (a*x[i])*x[j] into sum

    typedef struct packed {
        logic             accept;
        logic             init;
        logic             fetch;
        logic             mul;
        logic             prod;
        logic             rnd;
        logic             add;
        logic             done;
        logic             trans;
        logic [2:0]       step;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

[hw/rtl/qfe_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qfe_ctrl
// input handshake and term sequencer over the (i, j) index pairs
// ----------------------------------------------------------------------------
module qfe_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [2:0]  i_mode,
    input  wire logic        i_last,
    output logic             o_stall,
    input  qfe_pkg::t_sts    i_sts,
    output qfe_pkg::t_cmd    o_cmd
);
    import qfe_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_PROD  = 3'd4;
    localparam logic [2:0] S_RND   = 3'd5;
    localparam logic [2:0] S_ADD   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_VARIABLES - 1);

    logic [2:0]       r_state, n_state;
    logic [2:0]       r_step, n_step;
    logic [IDX_W-1:0] r_i, n_i, r_j, n_j;
    logic             r_trans, n_trans;
    logic             accept, start;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign start   = accept && i_last && (i_mode == MODE_EVAL || i_mode == MODE_TRANS);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_i     = r_i;
        n_j     = r_j;
        n_trans = r_trans;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_trans = (i_mode == MODE_TRANS);
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_i     = '0;
                n_j     = '0;
                n_step  = STEP_LIN;
                n_state = S_FETCH;
            end
            S_FETCH: n_state = S_MUL;
            S_MUL:   n_state = S_PROD;
            S_PROD:  n_state = S_RND;
            S_RND:   n_state = S_ADD;
            S_ADD: begin
                n_state = S_FETCH;
                case (r_step)
                    STEP_LIN: begin
                        if (!r_trans) begin
                            n_j    = '0;
                            n_step = STEP_XX;
                        end else if (r_i != IDX_LAST) begin
                            n_i = r_i + 1'b1;
                        end else begin
                            n_i    = '0;
                            n_j    = '0;
                            n_step = STEP_BI;
                        end
                    end
                    STEP_XX: begin
                        n_step  = STEP_XXA;
                        n_state = S_MUL;
                    end
                    STEP_BI: begin
                        n_step  = STEP_BJ;
                        n_state = S_MUL;
                    end
                    STEP_BJ: begin
                        n_step  = STEP_AXI;
                        n_state = S_MUL;
                    end
                    STEP_AXI: begin
                        n_step  = STEP_AXIJ;
                        n_state = S_MUL;
                    end
                    STEP_XXA, STEP_AXIJ: begin
                        if (r_j != IDX_LAST) begin
                            n_j    = r_j + 1'b1;
                            n_step = r_trans ? STEP_BI : STEP_XX;
                        end else if (r_i != IDX_LAST) begin
                            n_i    = r_i + 1'b1;
                            n_j    = '0;
                            n_step = r_trans ? STEP_BI : STEP_LIN;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= STEP_LIN;
            r_i     <= '0;
            r_j     <= '0;
            r_trans <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_i     <= n_i;
            r_j     <= n_j;
            r_trans <= n_trans;
        end
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = accept;
        o_cmd.init   = (r_state == S_INIT);
        o_cmd.fetch  = (r_state == S_FETCH);
        o_cmd.mul    = (r_state == S_MUL);
        o_cmd.prod   = (r_state == S_PROD);
        o_cmd.rnd    = (r_state == S_RND);
        o_cmd.add    = (r_state == S_ADD);
        o_cmd.done   = (r_state == S_DONE) && i_sts.out_free;
        o_cmd.trans  = r_trans;
        o_cmd.step   = r_step;
        o_cmd.i      = r_i;
        o_cmd.j      = r_j;
    end

endmodule
`default_nettype wire

[hw/rtl/qfe_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qfe_datapath
// coefficient storage, vector buffer, one multiplier, round and saturate
// ----------------------------------------------------------------------------
module qfe_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [2:0]         i_mode,
    input  wire logic [2:0]         i_row,
    input  wire logic [2:0]         i_col,
    input  wire logic signed [31:0] i_value,
    input  qfe_pkg::t_cmd           i_cmd,
    output qfe_pkg::t_sts           o_sts,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_result,
    output logic                    o_overflow
);
    import qfe_pkg::*;

    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    logic signed [31:0] r_amem [A_DEPTH];
    logic [A_DEPTH-1:0] r_avalid;
    logic signed [31:0] r_b [NUM_VARIABLES];
    logic signed [31:0] r_x [NUM_VARIABLES];
    logic signed [31:0] r_c;

    logic signed [31:0] r_a_rd;
    logic               r_a_vld;
    logic signed [31:0] r_xi;
    logic signed [31:0] r_ma, r_mb;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_q;
    logic signed [31:0] r_acc;
    logic               r_sat;
    logic               r_out_valid;
    logic signed [31:0] r_result;
    logic               r_ovf;

    logic               row_ok, col_ok;
    logic [IDX_W-1:0]   row_idx;
    logic [A_AW-1:0]    wr_addr, rd_addr;
    logic [IDX_W-1:0]   b_addr, x_addr;
    logic signed [31:0] b_rd, x_rd, a_val;
    logic signed [31:0] n_ma, n_mb;
    logic signed [63:0] rnd_sum, rnd_sh;
    logic signed [31:0] rnd_q;
    logic               rnd_sat;
    logic               dest_acc, dest_b;
    logic signed [31:0] add_a;
    logic signed [32:0] add_sum;
    logic signed [31:0] add_q;
    logic               add_sat;

    assign row_ok  = (32'(i_row) < 32'(NUM_VARIABLES));
    assign col_ok  = (32'(i_col) < 32'(NUM_VARIABLES));
    assign row_idx = IDX_W'(i_row);
    assign wr_addr = A_AW'(32'(i_row) * 32'(NUM_VARIABLES) + 32'(i_col));
    assign rd_addr = A_AW'(32'(i_cmd.i) * 32'(NUM_VARIABLES) + 32'(i_cmd.j));
    assign b_addr  = (i_cmd.step == STEP_BJ) ? i_cmd.j : i_cmd.i;
    assign x_addr  = i_cmd.fetch ? i_cmd.i : i_cmd.j;
    assign b_rd    = r_b[b_addr];
    assign x_rd    = r_x[x_addr];
    assign a_val   = r_a_vld ? r_a_rd : 32'sd0;

    // operand selection
    always_comb begin
        case (i_cmd.step)
            STEP_LIN:  begin n_ma = b_rd;  n_mb = r_xi;  end
            STEP_XX:   begin n_ma = r_xi;  n_mb = x_rd;  end
            STEP_XXA:  begin n_ma = r_q;   n_mb = a_val; end
            STEP_BI:   begin n_ma = a_val; n_mb = x_rd;  end
            STEP_BJ:   begin n_ma = a_val; n_mb = r_xi;  end
            STEP_AXI:  begin n_ma = a_val; n_mb = r_xi;  end
            STEP_AXIJ: begin n_ma = r_q;   n_mb = x_rd;  end
            default:   begin n_ma = 32'sd0; n_mb = 32'sd0; end
        endcase
    end

    // round half up to Q16.16 and saturate
    always_comb begin
        rnd_sum = r_prod + 64'sd32768;
        rnd_sh  = rnd_sum >>> 16;
        rnd_sat = (rnd_sh[63:31] != {33{1'b0}}) && (rnd_sh[63:31] != {33{1'b1}});
        if (rnd_sat) rnd_q = rnd_sh[63] ? S32_MIN : S32_MAX;
        else         rnd_q = rnd_sh[31:0];
    end

    assign dest_acc = (i_cmd.step == STEP_LIN) || (i_cmd.step == STEP_XXA) ||
                      (i_cmd.step == STEP_AXIJ);
    assign dest_b   = (i_cmd.step == STEP_BI) || (i_cmd.step == STEP_BJ);

    always_comb begin
        add_a   = dest_b ? b_rd : r_acc;
        add_sum = {add_a[31], add_a} + {r_q[31], r_q};
        add_sat = (add_sum[32] != add_sum[31]);
        if (add_sat) add_q = add_sum[32] ? S32_MIN : S32_MAX;
        else         add_q = add_sum[31:0];
    end

    // coefficient memory, no reset, read registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_mode == MODE_WR_QUAD && row_ok && col_ok)
            r_amem[wr_addr] <= i_value;
        r_a_rd <= r_amem[rd_addr];
    end

    // arithmetic pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) r_xi <= x_rd;
        if (i_cmd.mul) begin
            r_ma <= n_ma;
            r_mb <= n_mb;
        end
        if (i_cmd.prod) r_prod <= r_ma * r_mb;
        if (i_cmd.rnd)  r_q <= rnd_q;
        if (i_cmd.init) r_acc <= r_c;
        else if (i_cmd.add && dest_acc) r_acc <= add_q;
        if (i_cmd.done) begin
            r_result <= r_acc;
            r_ovf    <= r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avalid    <= '0;
            r_a_vld     <= 1'b0;
            r_c         <= 32'sd0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_VARIABLES; k++) begin
                r_b[k] <= 32'sd0;
                r_x[k] <= 32'sd0;
            end
        end else begin
            r_a_vld <= r_avalid[rd_addr];
            if (i_cmd.accept) begin
                case (i_mode)
                    MODE_WR_QUAD: if (row_ok && col_ok) r_avalid[wr_addr] <= 1'b1;
                    MODE_WR_LIN:  if (row_ok) r_b[row_idx] <= i_value;
                    MODE_WR_CONST: r_c <= i_value;
                    MODE_EVAL, MODE_TRANS: if (row_ok) r_x[row_idx] <= i_value;
                    MODE_CLEAR: begin
                        r_avalid <= '0;
                        r_c      <= 32'sd0;
                        for (int k = 0; k < NUM_VARIABLES; k++) begin
                            r_b[k] <= 32'sd0;
                            r_x[k] <= 32'sd0;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.init) r_sat <= 1'b0;
            else if ((i_cmd.rnd && rnd_sat) || (i_cmd.add && (dest_acc || dest_b) && add_sat))
                r_sat <= 1'b1;
            if (i_cmd.add && dest_b) r_b[b_addr] <= add_q;
            if (i_cmd.done) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
            if (i_cmd.done) begin
                if (i_cmd.trans) r_c <= r_acc;
                for (int k = 0; k < NUM_VARIABLES; k++) r_x[k] <= 32'sd0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_stall;
    assign o_valid        = r_out_valid;
    assign o_result       = r_result;
    assign o_overflow     = r_ovf;

endmodule
`default_nettype wire

[hw/rtl/quadratic_form_engine_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_form_engine_top
// evaluates or translates f(x) = c + b.x + x'Ax in signed Q16.16
// ----------------------------------------------------------------------------
// Coefficient writes, vector elements and clear are accepted whenever the
// sequencer is idle. A vector element marked last starts a walk of the term
// sequencer through one shared 32x32 multiplier; every product passes
// operand selection, multiply, round and accumulate, and each new index pair
// first passes a fetch step for the coefficient memory read. When the walk
// ends the result transaction is offered; input is stalled from the start of
// the walk until the result can enter the output register. A finished result
// may wait in the output register while new coefficient or vector
// transactions are accepted.
module quadratic_form_engine_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_mode,
    input  wire logic [2:0]         i_row,
    input  wire logic [2:0]         i_col,
    input  wire logic signed [31:0] i_value,
    input  wire logic               i_last,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_result,
    output logic                    o_overflow
);
    import qfe_pkg::*;

    // command and status between sequencer and datapath
    t_cmd w_cmd;
    t_sts w_sts;

    qfe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .i_last  (i_last),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    qfe_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (i_mode),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_value    (i_value),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result),
        .o_overflow (o_overflow)
    );

    // a last vector element starts the sequencer, which blocks input
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last && (i_mode == MODE_EVAL || i_mode == MODE_TRANS))
        |=> o_stall)
        else $error("sequencer did not start on last element");

    // a result appears only from the sequencer finishing
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.done))
        else $error("result without finished operation");

    // the finish never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.done |-> (!o_valid || !i_stall))
        else $error("pending result overwritten");

endmodule
`default_nettype wire

[tb/quadratic_form_engine_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_form_engine_top_test
// Self-checking bench for the quadratic form engine. A queue of pending
// transactions feeds a clocked driver. Every accepted transaction updates a
// local copy of the coefficients and of the vector buffer, and any result it
// causes is queued. A clocked monitor compares each result transaction with
// the oldest queued expectation.
// ----------------------------------------------------------------------------
module quadratic_form_engine_top_test;
    import qfe_pkg::*;

    localparam int  NV          = NUM_VARIABLES;
    localparam int  RAND_ITEMS  = 900;
    localparam int  CYCLE_LIMIT = 3_000_000;
    localparam int  TAIL_CYCLES = 1200;      // beyond one translation walk
    localparam int  HOLD_CYCLES = 4000;      // long receiver hold-off
    localparam int  HOLD_AT     = 450;       // accepted count that starts it

    typedef struct packed {
        logic [2:0]         mode;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] value;
        logic               last;
    } t_op;

    typedef struct packed {
        logic signed [31:0] result;
        logic               overflow;
    } t_res;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_mode = '0;
    logic [2:0]         i_row = '0;
    logic [2:0]         i_col = '0;
    logic signed [31:0] i_value = '0;
    logic               i_last = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_result;
    logic               o_overflow;

    quadratic_form_engine_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_mode     (i_mode),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_value    (i_value),
        .i_last     (i_last),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result),
        .o_overflow (o_overflow)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_op  pending_ops[$];
    t_res expected_results[$];

    // shadow copy of the function held by the block
    logic signed [31:0] mat_a [NV*NV];
    logic signed [31:0] lin_b [NV];
    logic signed [31:0] const_c;
    logic signed [31:0] vec_x [NV];
    logic               sat_seen;

    int  accepted_ops = 0;
    int  error_count  = 0;
    int  cycle_count  = 0;
    int  hold_left    = 0;
    bit  hold_done    = 0;
    bit  in_xfer      = 0;
    bit  stim_done    = 0;
    int  send_idle_pct;
    int  recv_idle_pct;

    // ------------------------------------------------------------------------
    // saturating Q16.16 arithmetic
    // ------------------------------------------------------------------------
    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) begin
            sat_seen = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            sat_seen = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                   logic signed [31:0] b);
        return clamp32(longint'(a) + longint'(b));
    endfunction

    // round to nearest, ties toward plus infinity (floor of p + 1/2)
    function automatic logic signed [31:0] q_mul(logic signed [31:0] a,
                                                 logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd32768;
        return clamp32(p >>> 16);
    endfunction

    function automatic logic signed [31:0] evaluate_form();
        logic signed [31:0] sum;
        logic signed [31:0] xx;
        sum = const_c;
        for (int i = 0; i < NV; i++) begin
            sum = sat_add(sum, q_mul(lin_b[i], vec_x[i]));
            for (int j = 0; j < NV; j++) begin
                xx  = q_mul(vec_x[i], vec_x[j]);
                sum = sat_add(sum, q_mul(xx, mat_a[i*NV+j]));
            end
        end
        return sum;
    endfunction

    // shift the function by the buffered vector, old b enters c first
    function automatic void translate_form();
        logic signed [31:0] a;
        for (int i = 0; i < NV; i++)
            const_c = sat_add(const_c, q_mul(lin_b[i], vec_x[i]));
        for (int i = 0; i < NV; i++) begin
            for (int j = 0; j < NV; j++) begin
                a        = mat_a[i*NV+j];
                lin_b[i] = sat_add(lin_b[i], q_mul(a, vec_x[j]));
                lin_b[j] = sat_add(lin_b[j], q_mul(a, vec_x[i]));
                const_c  = sat_add(const_c, q_mul(q_mul(a, vec_x[i]), vec_x[j]));
            end
        end
    endfunction

    function automatic void clear_form();
        foreach (mat_a[k]) mat_a[k] = '0;
        foreach (lin_b[k]) lin_b[k] = '0;
        foreach (vec_x[k]) vec_x[k] = '0;
        const_c = '0;
    endfunction

    // apply one accepted transaction to the shadow state
    function automatic void apply_op(t_op op);
        t_res r;
        case (op.mode)
            MODE_WR_QUAD: begin
                if (op.row < NV && op.col < NV) mat_a[op.row*NV+op.col] = op.value;
            end
            MODE_WR_LIN: begin
                if (op.row < NV) lin_b[op.row] = op.value;
            end
            MODE_WR_CONST: begin
                const_c = op.value;
            end
            MODE_EVAL, MODE_TRANS: begin
                if (op.row < NV) vec_x[op.row] = op.value;
                if (op.last) begin
                    sat_seen = 1'b0;
                    // the element carrying last picks the operation
                    if (op.mode == MODE_EVAL) begin
                        r.result = evaluate_form();
                    end else begin
                        translate_form();
                        r.result = const_c;
                    end
                    r.overflow = sat_seen;
                    foreach (vec_x[k]) vec_x[k] = '0;
                    expected_results.push_back(r);
                end
            end
            MODE_CLEAR: begin
                clear_form();
            end
            default: ;  // unused modes are dropped
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        if (sel < 90) return $urandom;
        if (sel < 95) return 32'sh7fffffff;
        return 32'sh80000000;
    endfunction

    function automatic void push_op(logic [2:0] mode, logic [2:0] row, logic [2:0] col,
                                    logic signed [31:0] value, logic last);
        t_op op;
        op.mode  = mode;
        op.row   = row;
        op.col   = col;
        op.value = value;
        op.last  = last;
        pending_ops.push_back(op);
    endfunction

    // ------------------------------------------------------------------------
    // driver: new transaction at the falling edge once the last one is taken
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_xfer)) begin
            if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                t_op op;
                op = pending_ops.pop_front();
                i_mode  <= op.mode;
                i_row   <= op.row;
                i_col   <= op.col;
                i_value <= op.value;
                i_last  <= op.last;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold-off so the block backs up
    always @(negedge i_clk) begin
        if (!hold_done && accepted_ops >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // idling phases follow the accepted count
    always_comb begin
        if (accepted_ops < 300) begin
            send_idle_pct = 6;
            recv_idle_pct = 71;
        end else if (accepted_ops < 600) begin
            send_idle_pct = 71;
            recv_idle_pct = 6;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // ------------------------------------------------------------------------
    // input acceptance, prediction, result checking and timeout
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            in_xfer <= i_rst_n && i_valid && !o_stall;
            if (i_rst_n && i_valid && !o_stall) begin
                t_op op;
                op.mode  = i_mode;
                op.row   = i_row;
                op.col   = i_col;
                op.value = i_value;
                op.last  = i_last;
                apply_op(op);
                accepted_ops <= accepted_ops + 1;
            end
            if (i_rst_n && o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    error_count <= error_count + 1;
                    if (error_count < 10)
                        $display("unexpected result transaction: result=%h overflow=%b",
                                 o_result, o_overflow);
                end else begin
                    t_res want;
                    want = expected_results.pop_front();
                    if (want.result !== o_result || want.overflow !== o_overflow) begin
                        error_count <= error_count + 1;
                        if (error_count < 10)
                            $display("mismatch: expected result=%h overflow=%b, got %h %b",
                                     want.result, want.overflow, o_result, o_overflow);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int n;
        int len;
        clear_form();
        sat_seen = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, every mode, ignored modes, mixed vectors
        push_op(MODE_WR_QUAD,  3'd0, 3'd0, 32'sh7fffffff, 1'b1);  // last ignored on writes
        push_op(MODE_WR_QUAD,  3'd7, 3'd7, 32'sh80000000, 1'b0);
        push_op(MODE_WR_QUAD,  3'd3, 3'd5, 32'sh0001_0000, 1'b0);
        push_op(MODE_WR_LIN,   3'd7, 3'd7, 32'sh0002_8000, 1'b0);
        push_op(MODE_WR_LIN,   3'd0, 3'd0, 32'shffff_0000, 1'b0);
        push_op(MODE_WR_CONST, 3'd0, 3'd0, 32'sh0000_8000, 1'b0);
        push_op(MODE_EVAL,     3'd0, 3'd0, 32'sh0000_0000, 1'b1);  // f(0) = c
        push_op(MODE_EVAL,     3'd0, 3'd0, 32'sh7fffffff, 1'b0);
        push_op(MODE_EVAL,     3'd7, 3'd0, 32'sh80000000, 1'b1);  // saturates
        push_op(MODE_EVAL,     3'd3, 3'd0, 32'sh0001_0000, 1'b0);
        push_op(MODE_EVAL,     3'd5, 3'd0, 32'shffff_8000, 1'b1);
        push_op(3'd6,          3'd1, 3'd2, 32'sh1234_5678, 1'b1);  // unused mode
        push_op(3'd7,          3'd7, 3'd7, 32'shffff_ffff, 1'b1);  // unused mode
        push_op(MODE_EVAL,     3'd3, 3'd0, 32'sh0000_8000, 1'b0);  // eval element ...
        push_op(MODE_TRANS,    3'd5, 3'd0, 32'sh0001_0000, 1'b1);  // ... translate wins
        push_op(MODE_TRANS,    3'd0, 3'd0, 32'sh0000_0001, 1'b0);
        push_op(MODE_EVAL,     3'd7, 3'd0, 32'sh0000_0002, 1'b1);  // eval wins
        push_op(MODE_TRANS,    3'd7, 3'd0, 32'sh7fffffff, 1'b1);
        push_op(MODE_CLEAR,    3'd0, 3'd0, 32'sh0000_0000, 1'b1);
        push_op(MODE_EVAL,     3'd4, 3'd0, 32'sh0003_0000, 1'b1);  // all zero after clear
        push_op(MODE_TRANS,    3'd2, 3'd0, 32'sh0003_0000, 1'b1);

        // sender pause: let every expected result come back
        wait (pending_ops.size() == 0 && expected_results.size() == 0);

        // random: mostly coefficient updates followed by complete vectors
        n = 0;
        while (n < RAND_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
                len = $urandom_range(0, 4);
                for (int k = 0; k < len; k++) begin
                    push_op(3'($urandom_range(MODE_WR_QUAD, MODE_WR_CONST)), 3'($urandom),
                            3'($urandom), pick_value(), 1'($urandom));
                end
                len = $urandom_range(1, NV);
                for (int k = 0; k < len; k++) begin
                    push_op(($urandom_range(0, 3) == 0) ? MODE_TRANS : MODE_EVAL,
                            3'($urandom), 3'($urandom), pick_value(), k == len - 1);
                end
                n += len + 1;
            end else begin
                // noise: any field combination, clear included
                push_op(3'($urandom_range(0, 7)), 3'($urandom), 3'($urandom), $urandom,
                        1'($urandom));
                n++;
            end
        end

        wait (pending_ops.size() == 0 && !i_valid);
        wait (expected_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[quadratic_form_engine_top.f]
hw/rtl/qfe_pkg.sv
hw/rtl/qfe_ctrl.sv
hw/rtl/qfe_datapath.sv
hw/rtl/quadratic_form_engine_top.sv
tb/quadratic_form_engine_top_test.sv
